// ===== hw/rtl/sfc_pkg.sv =====
// Shared types and constants for the sphere frustum cull block.
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = 3;
    localparam int FIELD_W    = 32;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 136;
    localparam int OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TEST  = 2'd2
    } t_op;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

// ===== hw/rtl/sfc_plane_eval.sv =====
// Three-stage signed distance test of one sphere against one clip plane.
`timescale 1ns / 1ps

module sfc_plane_eval #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           i_clk,
    input  sfc_pkg::t_stage_en             i_en,
    input  logic signed [COORD_WIDTH-1:0]  i_nx,
    input  logic signed [COORD_WIDTH-1:0]  i_ny,
    input  logic signed [COORD_WIDTH-1:0]  i_nz,
    input  logic signed [COORD_WIDTH-1:0]  i_d,
    input  logic signed [COORD_WIDTH-1:0]  i_cx,
    input  logic signed [COORD_WIDTH-1:0]  i_cy,
    input  logic signed [COORD_WIDTH-1:0]  i_cz,
    input  logic signed [COORD_WIDTH-1:0]  i_r,
    output logic                           o_reject
);
    import sfc_pkg::*;

    localparam int PW = 2 * COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;
    localparam int AW = 2 * COORD_WIDTH + 3;

    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [PW-1:0] r_pz;
    logic signed [DW-1:0] r_dr;
    logic signed [AW-1:0] r_ab;
    logic signed [AW-1:0] r_c;
    logic signed [AW-1:0] w_diff;
    logic                 r_rej;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_px <= PW'(i_nx) * PW'(i_cx);
            r_py <= PW'(i_ny) * PW'(i_cy);
            r_pz <= PW'(i_nz) * PW'(i_cz);
            r_dr <= DW'(i_d) - DW'(i_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_ab <= (AW'(r_dr) <<< FRAC_BITS) - AW'(r_px);
            r_c  <= AW'(r_py) + AW'(r_pz);
        end
    end

    assign w_diff = r_ab - r_c;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_rej <= !w_diff[AW-1] && (w_diff != '0);
        end
    end

    assign o_reject = r_rej;

endmodule

// ===== hw/rtl/sphere_frustum_cull.sv =====
// Top level of the sphere frustum cull block: plane table and result pipeline.
// A read or test beat gives its result beat after the pipeline stages; stalls hold it.
// Beats are accepted one per cycle unless stalled; a write updates the table at
// acceptance and gives no result beat, and every later beat sees the new plane.
// Synchronous active-low reset clears the plane table and all valid bits.
`timescale 1ns / 1ps

module sphere_frustum_cull #(
    parameter int PLANE_COUNT = 8,
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // plane_index, coord_x, coord_y, coord_z, coord_w, zero fill
    input  logic [sfc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [sfc_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // inside_res, plane_x, plane_y, plane_z, plane_offset, zero fill
    output logic [sfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import sfc_pkg::*;

    localparam int IW = $clog2(PLANE_COUNT);
    localparam int XW = ((IW > IDX_W) ? IW : IDX_W) + 1;
    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0] r_nx [PLANE_COUNT];
    logic signed [CW-1:0] r_ny [PLANE_COUNT];
    logic signed [CW-1:0] r_nz [PLANE_COUNT];
    logic signed [CW-1:0] r_d  [PLANE_COUNT];

    logic                 w_acc;
    t_op                  w_op;
    logic [IDX_W-1:0]     w_idx;
    logic [XW-1:0]        w_idx_ext;
    logic [FIELD_W-1:0]   w_x;
    logic [FIELD_W-1:0]   w_y;
    logic [FIELD_W-1:0]   w_z;
    logic [FIELD_W-1:0]   w_w;

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                 w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    t_stage_en            w_en;

    logic                 r1_test;
    logic [XW-1:0]        r1_idx;
    logic signed [CW-1:0] r1_x, r1_y, r1_z, r1_w;
    logic                 w1_idx_ok;

    logic                 r2_test, r3_test, r4_test;
    logic [FIELD_W-1:0]   r2_rd [4];
    logic [FIELD_W-1:0]   r3_rd [4];
    logic [FIELD_W-1:0]   r4_rd [4];
    logic [PLANE_COUNT-1:0] w_rej;

    logic                 r5_inside;
    logic [FIELD_W-1:0]   r5_rd [4];

    assign w_op      = t_op'(s_axis_tuser);
    assign w_idx     = s_axis_tdata[IDX_W-1:0];
    assign w_idx_ext = XW'(w_idx);
    assign w_x       = s_axis_tdata[IDX_W +: FIELD_W];
    assign w_y       = s_axis_tdata[IDX_W + FIELD_W +: FIELD_W];
    assign w_z       = s_axis_tdata[IDX_W + 2*FIELD_W +: FIELD_W];
    assign w_w       = s_axis_tdata[IDX_W + 3*FIELD_W +: FIELD_W];

    assign w_rdy5 = !r_v5 || m_axis_tready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_en   = '{s2: w_rdy2, s3: w_rdy3, s4: w_rdy4};

    assign s_axis_tready = w_rdy1;
    assign w_acc         = s_axis_tvalid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                r_nx[i] <= '0;
                r_ny[i] <= '0;
                r_nz[i] <= '0;
                r_d[i]  <= '0;
            end
        end else if (w_acc && w_op == OP_WRITE && w_idx_ext < XW'(PLANE_COUNT)) begin
            r_nx[w_idx_ext[IW-1:0]] <= w_x[CW-1:0];
            r_ny[w_idx_ext[IW-1:0]] <= w_y[CW-1:0];
            r_nz[w_idx_ext[IW-1:0]] <= w_z[CW-1:0];
            r_d[w_idx_ext[IW-1:0]]  <= w_w[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= w_acc && (w_op == OP_READ || w_op == OP_TEST);
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_test <= (w_op == OP_TEST);
            r1_idx  <= w_idx_ext;
            r1_x    <= w_x[CW-1:0];
            r1_y    <= w_y[CW-1:0];
            r1_z    <= w_z[CW-1:0];
            r1_w    <= w_w[CW-1:0];
        end
    end

    assign w1_idx_ok = (r1_idx < XW'(PLANE_COUNT));

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_test <= r1_test;
            if (w1_idx_ok) begin
                r2_rd[0] <= FIELD_W'(r_nx[r1_idx[IW-1:0]]);
                r2_rd[1] <= FIELD_W'(r_ny[r1_idx[IW-1:0]]);
                r2_rd[2] <= FIELD_W'(r_nz[r1_idx[IW-1:0]]);
                r2_rd[3] <= FIELD_W'(r_d[r1_idx[IW-1:0]]);
            end else begin
                for (int k = 0; k < 4; k++) begin
                    r2_rd[k] <= '0;
                end
            end
        end
        if (w_rdy3) begin
            r3_test <= r2_test;
            r3_rd   <= r2_rd;
        end
        if (w_rdy4) begin
            r4_test <= r3_test;
            r4_rd   <= r3_rd;
        end
        if (w_rdy5) begin
            r5_inside <= r4_test && !(|w_rej);
            for (int k = 0; k < 4; k++) begin
                r5_rd[k] <= r4_test ? '0 : r4_rd[k];
            end
        end
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
        sfc_plane_eval #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_eval (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_nx     (r_nx[g]),
            .i_ny     (r_ny[g]),
            .i_nz     (r_nz[g]),
            .i_d      (r_d[g]),
            .i_cx     (r1_x),
            .i_cy     (r1_y),
            .i_cz     (r1_z),
            .i_r      (r1_w),
            .o_reject (w_rej[g])
        );
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = {
        (OUT_DATA_W - 1 - 4*FIELD_W)'(0),
        r5_rd[3], r5_rd[2], r5_rd[1], r5_rd[0], r5_inside
    };

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !m_axis_tready))
        else $error("input stalled while the pipeline has a free stage");

    a_write_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_WRITE) |=> !r_v1)
        else $error("write beat entered the result pipeline");

    a_test_zero_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[4*FIELD_W:1] == '0))
        else $error("test result carries plane data");

    a_table_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (r_nx[0] == '0 && r_d[0] == '0 && !r_v5))
        else $error("plane table not cleared by reset");

endmodule
